### rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared widths, request and status codes for the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

	localparam int DEF_CAPACITY   = 64;
	localparam int DEF_VALUE_BITS = 32;

	localparam int KEY_W       = 32;
	localparam int VALUE_W     = 32;
	localparam int CFG_W       = 7;
	localparam int STATUS_W    = 2;
	localparam int COUNT_OUT_W = 7;

	localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 7'd64;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_HIT      = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_MISS     = 2'd3;

endpackage

### rtl/skt_if.sv
// ----------------------------------------------------------------------------
// skt_if
// Valid/ready channels of the sorted key table: config, request, response.
// ----------------------------------------------------------------------------
interface skt_cfg_if;
	import skt_pkg::*;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] max_entries;
	modport source(output valid, output max_entries, input ready);
	modport sink(input valid, input max_entries, output ready);
endinterface

interface skt_req_if;
	import skt_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    req_type;
	logic signed [KEY_W-1:0] key;
	logic [VALUE_W-1:0]      value;
	modport source(output valid, output req_type, output key, output value, input ready);
	modport sink(input valid, input req_type, input key, input value, output ready);
endinterface

interface skt_rsp_if;
	import skt_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [STATUS_W-1:0]    status;
	logic [VALUE_W-1:0]     found_value;
	logic [COUNT_OUT_W-1:0] entry_count;
	modport source(output valid, output status, output found_value, output entry_count,
		input ready);
	modport sink(input valid, input status, input found_value, input entry_count,
		output ready);
endinterface

### rtl/skt_mem.sv
// ----------------------------------------------------------------------------
// skt_mem
// Key and value storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module skt_mem #(
	parameter int DEPTH      = skt_pkg::DEF_CAPACITY,
	parameter int VALUE_BITS = skt_pkg::DEF_VALUE_BITS
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [$clog2(DEPTH)-1:0]       wr_addr,
	input  logic signed [skt_pkg::KEY_W-1:0] wr_key,
	input  logic [VALUE_BITS-1:0]          wr_value,
	input  logic [$clog2(DEPTH)-1:0]       rd_addr,
	output logic signed [skt_pkg::KEY_W-1:0] rd_key,
	output logic [VALUE_BITS-1:0]          rd_value
);
	import skt_pkg::*;

	logic signed [KEY_W-1:0] key_mem [DEPTH];
	logic [VALUE_BITS-1:0]   val_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			val_mem[wr_addr] <= wr_value;
		end
	end

	always_ff @(posedge clk) begin
		rd_key   <= key_mem[rd_addr];
		rd_value <= val_mem[rd_addr];
	end

endmodule

### rtl/sorted_key_table_insert_lookup.sv
// ----------------------------------------------------------------------------
// sorted_key_table_insert_lookup
// Sorted key/value table with lower-bound insert and binary-search lookup.
// ----------------------------------------------------------------------------
// One request is processed at a time. Each binary search step is a memory
// read, then a compare, since all table accesses go through a single memory
// read port with a registered read. An insert runs the search, moves every
// entry from the slot up by one (count - slot entries), then writes the new
// entry. A rejected insert skips the search. The response sits in an output
// register, so the next request is taken while the previous word waits on
// rsp.ready. The config port is always ready.
module sorted_key_table_insert_lookup #(
	parameter int CAPACITY   = skt_pkg::DEF_CAPACITY,
	parameter int VALUE_BITS = skt_pkg::DEF_VALUE_BITS
) (
	input logic        clk,
	input logic        arst_n,
	skt_cfg_if.sink    cfg,
	skt_req_if.sink    req,
	skt_rsp_if.source  rsp
);
	import skt_pkg::*;

	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SRCH   = 3'd1;
	localparam logic [2:0] ST_CMP    = 3'd2;
	localparam logic [2:0] ST_SHIFT  = 3'd3;
	localparam logic [2:0] ST_WRITE  = 3'd4;
	localparam logic [2:0] ST_RESULT = 3'd5;

	logic [2:0]              state_q;
	logic                    op_q;
	logic signed [KEY_W-1:0] key_q;
	logic [VALUE_BITS-1:0]   val_q;
	logic [CW-1:0]           lo_q, hi_q, mid_q, idx_q, count_q;
	logic [CFG_W-1:0]        max_q;
	logic [STATUS_W-1:0]     status_q;
	logic [VALUE_W-1:0]      found_q;
	logic                    rsp_valid_q;
	logic [STATUS_W-1:0]     rsp_status_q;
	logic [VALUE_W-1:0]      rsp_found_q;
	logic [COUNT_OUT_W-1:0]  rsp_count_q;

	logic                    wr_en;
	logic [AW-1:0]           wr_addr, rd_addr;
	logic signed [KEY_W-1:0] wr_key, rd_key;
	logic [VALUE_BITS-1:0]   wr_value, rd_value;

	logic [VALUE_BITS+VALUE_W-1:0]  val_ext;
	logic [VALUE_BITS+VALUE_W-1:0]  rd_ext;
	logic [CW+COUNT_OUT_W-1:0]      cnt_ext;
	logic [VALUE_BITS-1:0]          val_in;
	logic [VALUE_W-1:0]             rd_val32;
	logic                           tbl_full;
	logic                           rsp_load;
	logic [CW-1:0]                  span, mid, count_m1, idx_m1, idx_m2;

	assign val_ext  = {{VALUE_BITS{1'b0}}, req.value};
	assign val_in   = val_ext[VALUE_BITS-1:0];
	assign rd_ext   = {{VALUE_W{1'b0}}, rd_value};
	assign rd_val32 = rd_ext[VALUE_W-1:0];
	assign cnt_ext  = {{COUNT_OUT_W{1'b0}}, count_q};

	assign tbl_full = (CMPW'(count_q) >= CMPW'(max_q)) || (count_q >= CW'(CAPACITY));

	// output register takes a new word when empty or being drained this cycle
	assign rsp_load = (state_q == ST_RESULT) && (!rsp_valid_q || rsp.ready);

	// insert uses a lower-bound midpoint, lookup the inclusive l..r midpoint
	assign span     = hi_q - lo_q;
	assign mid      = (op_q == REQ_INSERT) ? (lo_q + (span >> 1))
	                                       : (lo_q + ((span - CW'(1)) >> 1));
	assign count_m1 = count_q - CW'(1);
	assign idx_m1   = idx_q - CW'(1);
	assign idx_m2   = idx_q - CW'(2);

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE);

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.found_value = rsp_found_q;
	assign rsp.entry_count = rsp_count_q;

	// The shift writes entry idx while reading idx-2, so the two ports never
	// touch the same entry and no forwarding is needed.
	always_comb begin
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = lo_q[AW-1:0];
		wr_key   = key_q;
		wr_value = val_q;
		case (state_q)
			ST_SRCH: begin
				if (lo_q < hi_q) begin
					rd_addr = mid[AW-1:0];
				end else begin
					rd_addr = count_m1[AW-1:0];
				end
			end
			ST_SHIFT: begin
				wr_en    = 1'b1;
				wr_addr  = idx_q[AW-1:0];
				wr_key   = rd_key;
				wr_value = rd_value;
				rd_addr  = idx_m2[AW-1:0];
			end
			ST_WRITE: begin
				wr_en = 1'b1;
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= REQ_INSERT;
			key_q        <= '0;
			val_q        <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			mid_q        <= '0;
			idx_q        <= '0;
			count_q      <= '0;
			max_q        <= MAX_ENTRIES_RST;
			status_q     <= STATUS_INSERTED;
			found_q      <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= STATUS_INSERTED;
			rsp_found_q  <= '0;
			rsp_count_q  <= '0;
		end else begin
			if (cfg.valid) begin
				max_q <= cfg.max_entries;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						op_q    <= req.req_type;
						key_q   <= req.key;
						val_q   <= val_in;
						lo_q    <= '0;
						hi_q    <= count_q;
						found_q <= '0;
						if (req.req_type == REQ_INSERT && tbl_full) begin
							status_q <= STATUS_FULL;
							state_q  <= ST_RESULT;
						end else begin
							state_q <= ST_SRCH;
						end
					end
				end
				ST_SRCH: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid;
						state_q <= ST_CMP;
					end else if (op_q == REQ_LOOKUP) begin
						status_q <= STATUS_MISS;
						state_q  <= ST_RESULT;
					end else begin
						idx_q   <= count_q;
						state_q <= (count_q > lo_q) ? ST_SHIFT : ST_WRITE;
					end
				end
				ST_CMP: begin
					if (rd_key < key_q) begin
						lo_q    <= mid_q + CW'(1);
						state_q <= ST_SRCH;
					end else if (op_q == REQ_INSERT || key_q < rd_key) begin
						hi_q    <= mid_q;
						state_q <= ST_SRCH;
					end else begin
						found_q  <= rd_val32;
						status_q <= STATUS_HIT;
						state_q  <= ST_RESULT;
					end
				end
				ST_SHIFT: begin
					idx_q <= idx_m1;
					if (idx_m1 <= lo_q) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					count_q  <= count_q + CW'(1);
					status_q <= STATUS_INSERTED;
					state_q  <= ST_RESULT;
				end
				ST_RESULT: begin
					if (rsp_load) begin
						rsp_status_q <= status_q;
						rsp_found_q  <= found_q;
						rsp_count_q  <= cnt_ext[COUNT_OUT_W-1:0];
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	skt_mem #(
		.DEPTH      (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_mem (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_key   (wr_key),
		.wr_value (wr_value),
		.rd_addr  (rd_addr),
		.rd_key   (rd_key),
		.rd_value (rd_value)
	);

endmodule

### rtl/skt_chk.sv
// ----------------------------------------------------------------------------
// skt_chk
// Port-level checks on the sorted key table, bound to the top level.
// ----------------------------------------------------------------------------
module skt_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_ready,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input logic [skt_pkg::STATUS_W-1:0]        rsp_status,
	input logic [skt_pkg::VALUE_W-1:0]         rsp_found_value,
	input logic [skt_pkg::COUNT_OUT_W-1:0]     rsp_entry_count
);
	import skt_pkg::*;

	// a stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_found_value) && $stable(rsp_entry_count))
		else $error("response word changed while stalled");

	// one request in flight: no new word taken right after one is accepted
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != STATUS_HIT |-> rsp_found_value == '0)
		else $error("found_value nonzero without a hit");

endmodule

bind sorted_key_table_insert_lookup skt_chk u_skt_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_found_value (rsp.found_value),
	.rsp_entry_count (rsp.entry_count)
);

### tb/sv/skt_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// skt_table_checker
// Watches the config, request and response channels of the sorted key table.
// It keeps its own copy of the table, works out the response word for every
// accepted request and compares it with the response words in order.
// ----------------------------------------------------------------------------
module skt_table_checker (
	input  logic clk,
	input  logic arst_n,
	skt_cfg_if   cfg,
	skt_req_if   req,
	skt_rsp_if   rsp,
	output int   fail_count,
	output int   pending
);
	import skt_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic [VALUE_W-1:0]     found_value;
		logic [COUNT_OUT_W-1:0] entry_count;
	} rsp_word_t;

	logic signed [KEY_W-1:0] tbl_key [DEF_CAPACITY];
	logic [VALUE_W-1:0]      tbl_val [DEF_CAPACITY];
	int                      tbl_count;
	int                      tbl_limit;
	rsp_word_t               expected_rsp_q[$];
	rsp_word_t               want;

	// Updates the table copy and returns the response word for one request.
	function automatic rsp_word_t apply_request(input logic rtype,
		input logic signed [KEY_W-1:0] k, input logic [VALUE_W-1:0] v);
		rsp_word_t w;
		int        lo;
		int        hi;
		int        mid;
		int        i;
		bit        hit;
		w.status      = STATUS_MISS;
		w.found_value = '0;
		if (rtype == REQ_INSERT) begin
			if (tbl_count >= tbl_limit || tbl_count >= DEF_CAPACITY) begin
				w.status = STATUS_FULL;
			end else begin
				// lower bound: new key lands ahead of equal keys
				lo = 0;
				hi = tbl_count;
				while (lo < hi) begin
					mid = lo + (hi - lo) / 2;
					if (tbl_key[mid] < k) lo = mid + 1;
					else hi = mid;
				end
				for (i = tbl_count; i > lo; i--) begin
					tbl_key[i] = tbl_key[i - 1];
					tbl_val[i] = tbl_val[i - 1];
				end
				tbl_key[lo] = k;
				tbl_val[lo] = v;
				tbl_count++;
				w.status = STATUS_INSERTED;
			end
		end else begin
			// plain midpoint search; with duplicates the first equal probe wins
			lo  = 0;
			hi  = tbl_count - 1;
			hit = 1'b0;
			while (lo <= hi && !hit) begin
				mid = lo + (hi - lo) / 2;
				if (tbl_key[mid] < k) lo = mid + 1;
				else if (k < tbl_key[mid]) hi = mid - 1;
				else begin
					hit           = 1'b1;
					w.status      = STATUS_HIT;
					w.found_value = tbl_val[mid];
				end
			end
		end
		w.entry_count = tbl_count[COUNT_OUT_W-1:0];
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_count  = 0;
			tbl_limit  = int'(MAX_ENTRIES_RST);
			fail_count = 0;
			pending    = 0;
			expected_rsp_q.delete();
		end else begin
			if (cfg.valid && cfg.ready) tbl_limit = int'(cfg.max_entries);
			if (req.valid && req.ready)
				expected_rsp_q.push_back(apply_request(req.req_type, req.key, req.value));
			if (rsp.valid && rsp.ready) begin
				if (expected_rsp_q.size() == 0) begin
					$error("response word with no request outstanding");
					fail_count++;
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						fail_count++;
					end
					if (rsp.found_value !== want.found_value) begin
						$error("found_value: expected %08h, got %08h", want.found_value,
							rsp.found_value);
						fail_count++;
					end
					if (rsp.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d", want.entry_count,
							rsp.entry_count);
						fail_count++;
					end
				end
			end
			pending = expected_rsp_q.size();
		end
	end

endmodule

### tb/sv/sorted_key_table_insert_lookup_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_key_table_insert_lookup_tb
// Drives inserts and lookups into the sorted key table under several entry
// limits, with bursty requests and a stalling response side. The checker
// beside the block predicts every response word; this module gives the verdict.
// ----------------------------------------------------------------------------
module sorted_key_table_insert_lookup_tb;
	import skt_pkg::*;

	localparam int QUIET_LIMIT     = 4000;
	localparam int TAIL_CYCLES     = 100;
	localparam int PHASE_COUNT     = 6;
	localparam int ITEMS_PER_PHASE = 222;

	typedef enum {RDY_ALWAYS, RDY_COIN, RDY_EVERY5, RDY_SPARSE} rsp_pace_e;

	logic clk;
	logic arst_n;

	skt_cfg_if cfg_ch();
	skt_req_if req_ch();
	skt_rsp_if rsp_ch();

	int fail_count;
	int pending;

	sorted_key_table_insert_lookup u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	skt_table_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_ch),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// response side: switches between stall patterns every so often
	rsp_pace_e rsp_pace  = RDY_ALWAYS;
	int        pace_left = 0;
	int        pace_tick = 0;
	logic      rsp_take  = 1'b0;
	assign rsp_ch.ready = rsp_take;

	always @(posedge clk) begin
		if (pace_left == 0) begin
			rsp_pace  <= rsp_pace_e'($urandom_range(0, 3));
			pace_left <= $urandom_range(20, 300);
		end else begin
			pace_left <= pace_left - 1;
		end
		pace_tick <= pace_tick + 1;
		case (rsp_pace)
			RDY_ALWAYS: rsp_take <= 1'b1;
			RDY_COIN:   rsp_take <= 1'($urandom_range(0, 1));
			RDY_EVERY5: rsp_take <= (pace_tick % 5 == 0);
			default:    rsp_take <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// watchdog on cycles with no word moving on any channel
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	int                      burst_left = 0;
	logic signed [KEY_W-1:0] sent_keys[$];
	int                      phase_limit [PHASE_COUNT] = '{1, 13, 32, 63, 7, 64};

	task automatic send_req(input logic rtype, input logic signed [KEY_W-1:0] k,
		input logic [VALUE_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			burst_left = $urandom_range(1, 40);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= rtype;
		req_ch.key      <= k;
		req_ch.value    <= v;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		burst_left--;
		if (rtype == REQ_INSERT) sent_keys.push_back(k);
	endtask

	// drop valid and wait until every response word has come back
	task automatic drain_table();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_limit(input int lim);
		cfg_ch.valid       <= 1'b1;
		cfg_ch.max_entries <= lim[CFG_W-1:0];
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// lookups mostly reuse inserted keys; small range keeps duplicates common
	function automatic logic signed [KEY_W-1:0] pick_key(input bit for_lookup);
		logic signed [KEY_W-1:0] k;
		int                      sel;
		sel = $urandom_range(0, 9);
		if (for_lookup && sent_keys.size() != 0 && sel < 6) begin
			k = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
		end else if (sel < 4) begin
			k = $signed($urandom_range(0, 16)) - 8;
		end else if (sel < 5) begin
			case ($urandom_range(0, 3))
				0:       k = 32'sh8000_0000;
				1:       k = 32'sh7FFF_FFFF;
				2:       k = '0;
				default: k = -1;
			endcase
		end else begin
			k = $urandom;
		end
		return k;
	endfunction

	task automatic run_random(input int n);
		logic                    rtype;
		logic [VALUE_W-1:0]      v;
		int                      i;
		for (i = 0; i < n; i++) begin
			rtype = $urandom_range(0, 1) ? REQ_LOOKUP : REQ_INSERT;
			case ($urandom_range(0, 7))
				0:       v = '0;
				1:       v = '1;
				default: v = $urandom;
			endcase
			send_req(rtype, pick_key(rtype == REQ_LOOKUP), v);
		end
	endtask

	initial begin
		int p;
		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.req_type    <= REQ_INSERT;
		req_ch.key         <= '0;
		req_ch.value       <= '0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.max_entries <= MAX_ENTRIES_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, key and value extremes, duplicates, hits and misses
		send_req(REQ_LOOKUP, 32'sd0, 32'h0);
		send_req(REQ_INSERT, 32'sd0, 32'h0000_0000);
		send_req(REQ_INSERT, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
		send_req(REQ_INSERT, 32'sh8000_0000, 32'h1234_5678);
		send_req(REQ_INSERT, -32'sd1, 32'hA5A5_A5A5);
		send_req(REQ_INSERT, 32'sd0, 32'h5A5A_5A5A);
		send_req(REQ_INSERT, 32'sd0, 32'hFFFF_FFFF);
		send_req(REQ_INSERT, 32'sd1, 32'h0000_0001);
		send_req(REQ_LOOKUP, 32'sh8000_0000, 32'hFFFF_FFFF);
		send_req(REQ_LOOKUP, 32'sh7FFF_FFFF, 32'h0);
		send_req(REQ_LOOKUP, 32'sd0, 32'h0);
		send_req(REQ_LOOKUP, -32'sd1, 32'h0);
		send_req(REQ_LOOKUP, 32'sd1, 32'h0);
		send_req(REQ_LOOKUP, 32'sd2, 32'h0);
		send_req(REQ_LOOKUP, 32'sh7FFF_FFFE, 32'h0);
		send_req(REQ_LOOKUP, 32'sh8000_0001, 32'h0);
		send_req(REQ_INSERT, 32'sh4000_0000, 32'h8000_0000);
		send_req(REQ_INSERT, -32'sh4000_0000, 32'h7FFF_FFFF);

		// limit below the count first, then up to full, then below again, then 64
		for (p = 0; p < PHASE_COUNT; p++) begin
			drain_table();
			write_limit(phase_limit[p]);
			run_random(ITEMS_PER_PHASE);
		end
		drain_table();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule
